>>> hw/rtl/adaptive_force_pi_controller_defines.svh
// Assertion macros for the adaptive force PI controller checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef ADAPTIVE_FORCE_PI_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_FORCE_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define AFPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AFPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/afpc_pkg.sv
// Shared types and constants of the adaptive force PI controller.
// No dependencies.
package afpc_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CfgW      = 24;
  localparam int unsigned InDataW   = 88;
  localparam int unsigned OutDataW  = 88;
  localparam int unsigned CntW      = 5;
  localparam logic [CntW-1:0] GdivLast = CntW'(15);
  localparam logic [CntW-1:0] RdivLast = CntW'(29);

  typedef enum logic {
    REG_KP = 1'b0,
    REG_KI = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_E,
    OP_DT_E,
    OP_ADD_E,
    OP_SQ_T,
    OP_DT_T,
    OP_ADD_T,
    OP_GDIV_INIT,
    OP_GDIV_STEP,
    OP_GDIV_END,
    OP_RDIV_STEP,
    OP_FMUL,
    OP_FCMD,
    OP_KP,
    OP_KIDT,
    OP_KIL,
    OP_KIH,
    OP_SUM1,
    OP_SUM2,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic req;
    logic cls;
    logic gtriv;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/afpc_ctrl.sv
// Sequencer of the adaptive force PI controller.
// Depends on afpc_pkg; drives afpc_dp through command and status structs.
module afpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  afpc_pkg::dp_status_t status_i,
  output afpc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_E, S_DT_E, S_ADD_E, S_SQ_T, S_DT_T, S_ADD_T,
    S_GDIV_INIT, S_GDIV_STEP, S_GDIV_END, S_RDIV,
    S_FMUL, S_FCMD, S_KP, S_KIDT, S_KIL, S_KIH, S_SUM1, S_SUM2, S_OUT
  } state_e;

  state_e                    state_q;
  logic [afpc_pkg::CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_SQ_E;
        S_SQ_E:   state_q <= S_DT_E;
        S_DT_E:   state_q <= S_ADD_E;
        S_ADD_E:  state_q <= S_SQ_T;
        S_SQ_T:   state_q <= S_DT_T;
        S_DT_T:   state_q <= S_ADD_T;
        S_ADD_T: begin
          if (status_i.req && status_i.cls) begin
            state_q <= S_GDIV_INIT;
          end else if (status_i.req) begin
            state_q <= S_RDIV;
            cnt_q   <= afpc_pkg::RdivLast;
          end else begin
            state_q <= S_FMUL;
          end
        end
        S_GDIV_INIT: begin
          state_q <= S_GDIV_STEP;
          cnt_q   <= afpc_pkg::GdivLast;
        end
        S_GDIV_STEP: begin
          // skip the remaining steps once the gain is known to be one
          if (status_i.gtriv || cnt_q == '0) state_q <= S_GDIV_END;
          else cnt_q <= cnt_q - 1'b1;
        end
        S_GDIV_END: begin
          state_q <= S_RDIV;
          cnt_q   <= afpc_pkg::RdivLast;
        end
        S_RDIV: begin
          if (cnt_q == '0) state_q <= S_FMUL;
          else cnt_q <= cnt_q - 1'b1;
        end
        S_FMUL:   state_q <= S_FCMD;
        S_FCMD:   state_q <= S_KP;
        S_KP:     state_q <= S_KIDT;
        S_KIDT:   state_q <= S_KIL;
        S_KIL:    state_q <= S_KIH;
        S_KIH:    state_q <= S_SUM1;
        S_SUM1:   state_q <= S_SUM2;
        S_SUM2:   state_q <= S_OUT;
        S_OUT:    if (status_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    unique case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? afpc_pkg::OP_LOAD : afpc_pkg::OP_NONE;
      S_SQ_E:      cmd_o.op = afpc_pkg::OP_SQ_E;
      S_DT_E:      cmd_o.op = afpc_pkg::OP_DT_E;
      S_ADD_E:     cmd_o.op = afpc_pkg::OP_ADD_E;
      S_SQ_T:      cmd_o.op = afpc_pkg::OP_SQ_T;
      S_DT_T:      cmd_o.op = afpc_pkg::OP_DT_T;
      S_ADD_T:     cmd_o.op = afpc_pkg::OP_ADD_T;
      S_GDIV_INIT: cmd_o.op = afpc_pkg::OP_GDIV_INIT;
      S_GDIV_STEP: cmd_o.op = afpc_pkg::OP_GDIV_STEP;
      S_GDIV_END:  cmd_o.op = afpc_pkg::OP_GDIV_END;
      S_RDIV:      cmd_o.op = afpc_pkg::OP_RDIV_STEP;
      S_FMUL:      cmd_o.op = afpc_pkg::OP_FMUL;
      S_FCMD:      cmd_o.op = afpc_pkg::OP_FCMD;
      S_KP:        cmd_o.op = afpc_pkg::OP_KP;
      S_KIDT:      cmd_o.op = afpc_pkg::OP_KIDT;
      S_KIL:       cmd_o.op = afpc_pkg::OP_KIL;
      S_KIH:       cmd_o.op = afpc_pkg::OP_KIH;
      S_SUM1:      cmd_o.op = afpc_pkg::OP_SUM1;
      S_SUM2:      cmd_o.op = afpc_pkg::OP_SUM2;
      S_OUT:       cmd_o.op = afpc_pkg::OP_OUT;
      default:     cmd_o.op = afpc_pkg::OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/afpc_dp.sv
// Datapath of the adaptive force PI controller: shared multiplier, two
// bit-serial dividers, state registers and the output register. Uses afpc_pkg.
module afpc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  afpc_pkg::dp_cmd_t                 cmd_i,
  output afpc_pkg::dp_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [afpc_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic [afpc_pkg::InDataW-1:0]      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [afpc_pkg::OutDataW-1:0]     out_data_o
);

  localparam int unsigned SW = afpc_pkg::SampleW;

  // configuration and persistent state
  logic [afpc_pkg::CfgW-1:0] kp_q, ki_q;
  logic [63:0]               esum_q, ssum_q;
  logic [16:0]               gain_q;
  logic signed [17:0]        prev_q;
  logic signed [31:0]        acc_q;
  logic                      out_valid_q;

  // per-request working registers
  logic signed [SW-1:0] tgt_q, frc_q, ftg_q;
  logic [15:0]          dt_q;
  logic                 req_q, cls_q, gtriv_q;
  logic signed [17:0]   e_q;
  logic signed [57:0]   prod_q;
  logic [63:0]          gr_q;
  logic [15:0]          gq_q;
  logic [16:0]          rrem_q;
  logic [29:0]          rdvd_q;
  logic signed [SW-1:0] fcmd_q;
  logic signed [17:0]   fe_q;
  logic signed [43:0]   kpterm_q;
  logic [39:0]          kidt_q;
  logic signed [38:0]   kil_q;
  logic signed [42:0]   kiterm_q;
  logic [afpc_pkg::OutDataW-1:0] out_q;

  // input fields
  logic signed [SW-1:0] in_pos, in_tgt, in_frc, in_ftg;
  logic [15:0]          in_dt;
  logic                 in_req, in_cls;
  assign in_pos = in_data_i[15:0];
  assign in_tgt = in_data_i[31:16];
  assign in_frc = in_data_i[47:32];
  assign in_ftg = in_data_i[63:48];
  assign in_dt  = in_data_i[79:64];
  assign in_req = in_data_i[80];
  assign in_cls = in_data_i[81];

  logic signed [17:0] in_e;
  logic [17:0]        in_ae;
  assign in_e  = 18'(in_pos) - 18'(in_tgt);
  assign in_ae = in_e[17] ? 18'(-in_e) : in_e;

  logic [16:0] at;
  logic [16:0] tgt_ext;
  assign tgt_ext = 17'(tgt_q);
  assign at = tgt_q[SW-1] ? 17'(-tgt_ext) : tgt_ext;

  logic [17:0] ae;
  assign ae = e_q[17] ? 18'(-e_q) : e_q;

  // shared multiplier: unsigned 36-bit by signed 21-bit
  logic [35:0]        mul_a;
  logic signed [20:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [18:0] dfe;
  assign dfe = 19'(fe_q) - 19'(prev_q);

  always_comb begin
    case (cmd_i.op)
      afpc_pkg::OP_SQ_E: begin mul_a = 36'(ae);           mul_b = 21'($signed({1'b0, ae})); end
      afpc_pkg::OP_DT_E,
      afpc_pkg::OP_DT_T: begin mul_a = prod_q[35:0];      mul_b = 21'($signed({1'b0, dt_q})); end
      afpc_pkg::OP_SQ_T: begin mul_a = 36'(at);           mul_b = 21'($signed({1'b0, at})); end
      afpc_pkg::OP_FMUL: begin mul_a = 36'(gain_q);       mul_b = 21'(ftg_q); end
      afpc_pkg::OP_KP:   begin mul_a = 36'(kp_q);         mul_b = 21'(dfe); end
      afpc_pkg::OP_KIDT: begin mul_a = 36'(ki_q);         mul_b = 21'($signed({1'b0, dt_q})); end
      afpc_pkg::OP_KIL:  begin mul_a = 36'(prod_q[19:0]); mul_b = 21'(fe_q); end
      afpc_pkg::OP_KIH:  begin mul_a = 36'(kidt_q[39:20]); mul_b = 21'(fe_q); end
      default:           begin mul_a = '0;                mul_b = '0; end
    endcase
  end
  assign mul_p = 58'($signed({1'b0, mul_a}) * mul_b);

  // saturating energy adds
  logic [64:0] esum_add, ssum_add;
  assign esum_add = {1'b0, esum_q} + {8'b0, prod_q[56:0]};
  assign ssum_add = {1'b0, ssum_q} + {8'b0, prod_q[56:0]};

  // gain divider step: 2r >= s decides the quotient bit
  logic [64:0] g_two;
  logic        g_ge;
  assign g_two = {gr_q, 1'b0};
  assign g_ge  = (g_two >= {1'b0, ssum_q});

  // relative error divider step
  logic [17:0] r_sh;
  logic        r_ge;
  assign r_sh = {rrem_q, rdvd_q[29]};
  assign r_ge = (r_sh >= {1'b0, at});

  // force command and error
  logic signed [41:0] fsh;
  logic signed [SW-1:0] fcmd;
  assign fsh = 42'(prod_q >>> 16);
  always_comb begin
    if (fsh > 42'sd32767)        fcmd = 16'sh7FFF;
    else if (fsh < -42'sd32768)  fcmd = 16'sh8000;
    else                         fcmd = fsh[15:0];
  end

  // integral term, floor division by 2^16
  logic signed [58:0] ki_full;
  assign ki_full = (59'(prod_q[38:0]) <<< 20) + 59'(kil_q);

  // velocity accumulate with saturation
  logic signed [45:0] vsum;
  logic signed [31:0] vsat;
  assign vsum = 46'(acc_q) + 46'(kpterm_q) + 46'(kiterm_q);
  always_comb begin
    if (vsum > 46'sh7FFF_FFFF)       vsat = 32'sh7FFF_FFFF;
    else if (vsum < -46'sh8000_0000) vsat = 32'sh8000_0000;
    else                             vsat = vsum[31:0];
  end

  // relative error result
  logic [15:0] rel;
  logic        rneg;
  assign rneg = e_q[17] ^ tgt_q[SW-1];
  always_comb begin
    if (!req_q) begin
      rel = '0;
    end else if (tgt_q == '0) begin
      if (e_q == '0)   rel = 16'h0000;
      else if (e_q[17]) rel = 16'h8000;
      else             rel = 16'h7FFF;
    end else if (rneg) begin
      rel = (rdvd_q > 30'd32768) ? 16'h8000 : 16'(-rdvd_q);
    end else begin
      rel = (rdvd_q > 30'd32767) ? 16'h7FFF : rdvd_q[15:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= 24'd94720;
      ki_q        <= 24'd896;
      esum_q      <= '0;
      ssum_q      <= '0;
      gain_q      <= '0;
      prev_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          afpc_pkg::REG_KP: kp_q <= cfg_wdata_i;
          default:          ki_q <= cfg_wdata_i;
        endcase
      end
      // raise valid when a result is written, drop it once taken
      if (cmd_i.op == afpc_pkg::OP_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        afpc_pkg::OP_ADD_E:    esum_q <= esum_add[64] ? '1 : esum_add[63:0];
        afpc_pkg::OP_ADD_T:    ssum_q <= ssum_add[64] ? '1 : ssum_add[63:0];
        afpc_pkg::OP_GDIV_END: begin
          gain_q <= gtriv_q ? 17'h10000 : {1'b0, gq_q};
          esum_q <= '0;
          ssum_q <= '0;
        end
        afpc_pkg::OP_SUM2: begin
          acc_q  <= vsat;
          prev_q <= fe_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      afpc_pkg::OP_LOAD: begin
        tgt_q  <= in_tgt;
        frc_q  <= in_frc;
        ftg_q  <= in_ftg;
        dt_q   <= in_dt;
        req_q  <= in_req;
        cls_q  <= in_cls;
        e_q    <= in_e;
        rrem_q <= '0;
        rdvd_q <= {in_ae, 12'b0};
      end
      afpc_pkg::OP_SQ_E, afpc_pkg::OP_DT_E, afpc_pkg::OP_SQ_T,
      afpc_pkg::OP_DT_T, afpc_pkg::OP_FMUL, afpc_pkg::OP_KP: prod_q <= mul_p;
      afpc_pkg::OP_GDIV_INIT: begin
        gtriv_q <= (ssum_q == '0) || (esum_q >= ssum_q);
        gr_q    <= esum_q;
        gq_q    <= '0;
      end
      afpc_pkg::OP_GDIV_STEP: begin
        gr_q <= g_ge ? 64'(g_two - {1'b0, ssum_q}) : g_two[63:0];
        gq_q <= {gq_q[14:0], g_ge};
      end
      afpc_pkg::OP_RDIV_STEP: begin
        rrem_q <= r_ge ? 17'(r_sh - {1'b0, at}) : r_sh[16:0];
        rdvd_q <= {rdvd_q[28:0], r_ge};
      end
      afpc_pkg::OP_FCMD: begin
        fcmd_q <= fcmd;
        // difference of two 16-bit values always fits the 18-bit error
        fe_q   <= 18'(fcmd) - 18'(frc_q);
      end
      afpc_pkg::OP_KIDT: begin
        kpterm_q <= prod_q[43:0];
        prod_q   <= mul_p;
      end
      afpc_pkg::OP_KIL: begin
        kidt_q <= prod_q[39:0];
        prod_q <= mul_p;
      end
      afpc_pkg::OP_KIH: begin
        kil_q  <= prod_q[38:0];
        prod_q <= mul_p;
      end
      afpc_pkg::OP_SUM1: kiterm_q <= 43'(ki_full >>> 16);
      afpc_pkg::OP_OUT: begin
        if (out_free) begin
          out_q <= {6'b0, tgt_q == '0 && req_q, req_q, rel, acc_q,
                    fcmd_q, tgt_q};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.req      = req_q;
  assign status_o.cls      = cls_q;
  assign status_o.gtriv    = gtriv_q;
  assign status_o.out_free = out_free;

endmodule

>>> hw/rtl/adaptive_force_pi_controller.sv
// The gain window close runs 16 gain divider steps and the error report 30
// quotient steps; the gain divider stops early once the gain is known to be one.
// Requests are handled one at a time; a new request can be taken in the cycle
// after the previous result is written to the output register, while that
// result waits. The serial dividers and the shared multiplier set the run time.
// Reset (rst_ni low, asynchronous): sums, gain, force error and velocity clear.
module adaptive_force_pi_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [afpc_pkg::CfgW-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // measured_position, position_target, measured_force, force_target,
  // delta_time, error_requested, close_window (lowest bit up), zero padded
  input  logic [afpc_pkg::InDataW-1:0]  s_axis_tdata,
  // result channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // position_command, force_command, velocity_command, relative_error,
  // relative_error_valid, divide_by_zero (lowest bit up), zero padded
  output logic [afpc_pkg::OutDataW-1:0] m_axis_tdata
);

  afpc_pkg::dp_cmd_t    cmd;
  afpc_pkg::dp_status_t status;

  // Sequencer: takes a request in idle, then steps the datapath through
  // energy update, optional gain window close, optional division, PI update.
  afpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: holds configuration, state and the output register; the output
  // register parts the result channel from the sequencer.
  afpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/afpc_checker.sv
// Port-level checks of the adaptive force PI controller, bound to the top.
// Depends on afpc_pkg and adaptive_force_pi_controller_defines.svh.
`include "adaptive_force_pi_controller_defines.svh"

module afpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [afpc_pkg::OutDataW-1:0] m_axis_tdata
);

  // one request in flight: ready drops after an accept
  `AFPC_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

  // a stalled result stays offered
  `AFPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // without a report the error fields are zero
  `AFPC_ASSERT_NOW(a_no_report, m_axis_tvalid && !m_axis_tdata[80], !m_axis_tdata[81] && m_axis_tdata[79:64] == 16'h0000, "error fields without request")

  // zero setpoint gives only saturated or zero error
  `AFPC_ASSERT_NOW(a_dz_value, m_axis_tvalid && m_axis_tdata[81], m_axis_tdata[79:64] == 16'h7FFF || m_axis_tdata[79:64] == 16'h8000 || m_axis_tdata[79:64] == 16'h0000, "bad zero-setpoint error")

endmodule

bind adaptive_force_pi_controller afpc_checker u_afpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
